/* sv/frame_accumulator_filtered_assert.svh */
`ifndef FRAME_ACCUMULATOR_FILTERED_ASSERT_SVH
`define FRAME_ACCUMULATOR_FILTERED_ASSERT_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low.
`define FAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, without a reset guard.
`define FAF_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/faf_pkg.sv */
package faf_pkg;

  localparam int unsigned MaxPixelsDefault = 1048576;
  localparam int unsigned PixW   = 33;
  localparam int unsigned TdataW = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 33;
  localparam int unsigned FpsW   = 16;
  localparam int unsigned StoreW = 32;
  localparam int unsigned DivCntW = 5;

  localparam logic [CfgIdxW-1:0] RegFramesPerSet = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFilterMode   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOperation    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThreshold    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOffset       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOutType      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInputSigned  = 3'd6;

  localparam logic [1:0] FilterNone   = 2'd0;
  localparam logic [1:0] FilterThresh = 2'd1;
  localparam logic [1:0] FilterOffset = 2'd2;

  localparam logic [1:0] TypeU32 = 2'd2;
  localparam logic [1:0] TypeS32 = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic capture;
    logic calc;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic mean;
    logic div_last;
    logic out_free;
  } sts_t;

  // Reduce a value to type t (0 u16, 1 s16, 2 u32, 3 s32), 33-bit signed result.
  function automatic logic signed [32:0] wrap_type(input logic [33:0] v, input logic [1:0] t);
    logic [31:0] lo;
    logic signed [32:0] r;
    lo = v[31:0];
    if (t[1]) begin
      r = {t[0] & lo[31], lo};
    end else begin
      r = {{17{t[0] & lo[15]}}, lo[15:0]};
    end
    return r;
  endfunction

endpackage

/* sv/faf_ctrl.sv */
module faf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  faf_pkg::sts_t   sts_i,
  output faf_pkg::cmd_t   cmd_o
);

  faf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= faf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      faf_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = faf_pkg::StCalc;
        end
      end
      faf_pkg::StCalc: begin
        cmd_o.calc = 1'b1;
        if (sts_i.emit) begin
          if (sts_i.mean) begin
            cmd_o.div_start = 1'b1;
            state_d         = faf_pkg::StDiv;
          end else begin
            state_d = faf_pkg::StOut;
          end
        end else begin
          state_d = faf_pkg::StIdle;
        end
      end
      faf_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = faf_pkg::StOut;
        end
      end
      faf_pkg::StOut: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = faf_pkg::StIdle;
        end
      end
      default: state_d = faf_pkg::StIdle;
    endcase
  end

endmodule

/* sv/faf_dp.sv */
module faf_dp #(
  parameter int unsigned MaxPixels = faf_pkg::MaxPixelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [faf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [faf_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [faf_pkg::TdataW-1:0]    s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [faf_pkg::TdataW-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast,
  input  faf_pkg::cmd_t                 cmd_i,
  output faf_pkg::sts_t                 sts_o
);

  localparam int unsigned IdxW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;
  localparam logic [IdxW:0] MaxIdx = (IdxW+1)'(MaxPixels);

  // configuration
  logic [15:0]        fps_reg_q;
  logic [1:0]         filter_q;
  logic               oper_q;
  logic signed [32:0] thr_q, off_q;
  logic [1:0]         out_type_q;
  logic               in_signed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_reg_q   <= 16'd1;
      filter_q    <= faf_pkg::FilterNone;
      oper_q      <= 1'b0;
      thr_q       <= '0;
      off_q       <= '0;
      out_type_q  <= faf_pkg::TypeS32;
      in_signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        faf_pkg::RegFramesPerSet: fps_reg_q   <= cfg_data_i[15:0];
        faf_pkg::RegFilterMode:   filter_q    <= cfg_data_i[1:0];
        faf_pkg::RegOperation:    oper_q      <= cfg_data_i[0];
        faf_pkg::RegThreshold:    thr_q       <= cfg_data_i;
        faf_pkg::RegOffset:       off_q       <= cfg_data_i;
        faf_pkg::RegOutType:      out_type_q  <= cfg_data_i[1:0];
        faf_pkg::RegInputSigned:  in_signed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [15:0] fps;
  logic [1:0]  acc_t;
  assign fps   = (fps_reg_q == 16'd0) ? 16'd1 : fps_reg_q;
  assign acc_t = oper_q ? (in_signed_q ? faf_pkg::TypeS32 : faf_pkg::TypeU32) : out_type_q;

  // counters
  logic [IdxW-1:0] idx_q;
  logic [15:0]     fis_q;
  logic            last_q;
  logic            last_frame;
  logic [IdxW:0]   idx_inc;
  assign last_frame = ({1'b0, fis_q} + 17'd1) >= {1'b0, fps};
  assign idx_inc    = {1'b0, idx_q} + {{IdxW{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      fis_q <= '0;
    end else if (cmd_i.calc) begin
      if (last_q) begin
        idx_q <= '0;
        fis_q <= last_frame ? 16'd0 : fis_q + 16'd1;
      end else begin
        idx_q <= (idx_inc >= MaxIdx) ? '0 : idx_inc[IdxW-1:0];
      end
    end
  end

  // pixel store
  logic [31:0] mem [MaxPixels];
  logic [31:0] rdata_q;
  logic signed [32:0] src_q;
  logic signed [32:0] acc_d, acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdata_q <= mem[idx_q];
      src_q   <= s_axis_tdata[32:0];
      last_q  <= s_axis_tlast;
    end
    if (cmd_i.calc) begin
      mem[idx_q] <= acc_d[31:0];
      acc_q      <= acc_d;
    end
  end

  // filter and accumulate
  logic signed [32:0] base, add, dval;
  logic signed [33:0] diff;
  always_comb begin
    base = (fis_q != 16'd0) ? faf_pkg::wrap_type({2'b00, rdata_q}, acc_t) : '0;
    diff = {src_q[32], src_q} - {off_q[32], off_q};
    dval = faf_pkg::wrap_type(diff, acc_t);
    if (!acc_t[0] && (src_q < off_q)) begin
      dval = '0;
    end
    case (filter_q)
      faf_pkg::FilterThresh: add = (src_q > thr_q) ? src_q : '0;
      faf_pkg::FilterOffset: add = (dval > thr_q) ? dval : '0;
      default:               add = src_q;
    endcase
    acc_d = faf_pkg::wrap_type({base[32], base} + {add[32], add}, acc_t);
  end

  // restoring divider, one quotient bit per cycle
  logic [15:0]  rem_q;
  logic [31:0]  quo_q;
  logic [faf_pkg::DivCntW-1:0] cnt_q;
  logic         neg_q;
  logic [16:0]  rem_sh;
  logic         fits;
  logic [16:0]  rem_sub;
  logic [32:0]  acc_neg;
  assign rem_sh  = {rem_q, quo_q[31]};
  assign fits    = rem_sh >= {1'b0, fps};
  assign rem_sub = rem_sh - {1'b0, fps};
  assign acc_neg = -acc_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= acc_d[32];
      rem_q <= '0;
      quo_q <= acc_d[32] ? acc_neg[31:0] : acc_d[31:0];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
      quo_q <= {quo_q[30:0], fits};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  logic [33:0]        qsigned;
  logic signed [32:0] res;
  assign qsigned = neg_q ? -{2'b00, quo_q} : {2'b00, quo_q};
  assign res     = oper_q ? faf_pkg::wrap_type(qsigned, out_type_q) : acc_q;

  // output register
  logic [32:0] out_val_q;
  logic        out_last_q;
  logic        m_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_val_q  <= res;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, out_val_q};
  assign m_axis_tlast  = out_last_q;

  assign sts_o.emit     = last_frame;
  assign sts_o.mean     = oper_q;
  assign sts_o.div_last = cnt_q == {faf_pkg::DivCntW{1'b1}};
  assign sts_o.out_free = !m_valid_q || m_axis_tready;

endmodule

/* sv/frame_accumulator_filtered.sv */
// Frame accumulator with per-pixel filter.
// Input stream (s_axis): one pixel per beat, tdata[32:0] signed pixel, tlast on the
// last pixel of a frame. Output stream (m_axis): one beat per pixel of the last
// frame of a set, tdata[32:0] sum or mean in the configured type, tlast = frame end.
// Config: cfg_we_i with cfg_idx_i selects frames_per_set, filter_mode, operation,
// pixel_threshold, pixel_offset, out_type, input_signed (index 0..6); write only
// while idle.
// Flow: a pixel that emits nothing is accepted, then the store read-modify-write is
// done. A sum result then goes to the output register; a mean result first passes
// through the bit-serial divider. No new pixel is taken until the last is through.
// The single-port pixel store is read at accept and written in the cycle after.
// Reset clears configuration, frame and pixel counters and the output valid; the
// store is not cleared, the first frame of each set overwrites it.
// When the receiver stalls the result waits in the output register; the next pixel
// is still accepted and processed, and the block then holds until the register frees.
module frame_accumulator_filtered #(
  parameter int unsigned MAX_PIXELS = faf_pkg::MaxPixelsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [faf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [faf_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [faf_pkg::TdataW-1:0]   s_axis_tdata,  // [32:0] pixel_value
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [faf_pkg::TdataW-1:0]   m_axis_tdata,  // [32:0] acc_value
  output logic                         m_axis_tlast
);

  faf_pkg::cmd_t cmd;
  faf_pkg::sts_t sts;

  faf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  faf_dp #(
    .MaxPixels (MAX_PIXELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

/* sv/faf_checker.sv */
`include "frame_accumulator_filtered_assert.svh"

module faf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [faf_pkg::TdataW-1:0]  m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  `FAF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output beat dropped")
  `FAF_ASSERT(a_one_at_a_time, s_acc |=> !s_axis_tready, "second beat taken during work")
  `FAF_ASSERT(a_no_early_out, s_acc |=> !$rose(m_axis_tvalid), "result before store update")
  `FAF_ASSERT_NR(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0, "tdata pad not zero")

endmodule

bind frame_accumulator_filtered faf_checker u_faf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
